### sv/rgb332_to_rgb565_doubling_bander_unit_macros.svh
// Assertion macros for the RGB332 to RGB565 doubling bander.
// Used by the RTL files that carry concurrent checks; needs clk and rst_n in scope.
`ifndef RGB332_TO_RGB565_DOUBLING_BANDER_UNIT_MACROS_SVH
`define RGB332_TO_RGB565_DOUBLING_BANDER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define R2RDB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define R2RDB_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define R2RDB_ASSERT(label, prop, msg)
`define R2RDB_ASSERT_NEVER(label, expr, msg)
`endif

`endif

### sv/r2rdb_pkg.sv
// Shared types and constants for the RGB332 to RGB565 doubling bander.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package r2rdb_pkg;

    localparam int PIXEL_W    = 8;
    localparam int COLOR_W    = 16;
    localparam int INDEX_W    = 14;
    localparam int BAND_ROW_W = 8;

    localparam logic [PIXEL_W-1:0] PIXEL_WHITE = 8'hFF;
    localparam logic [COLOR_W-1:0] COLOR_WHITE = 16'hFFFF;

    typedef struct packed {
        logic [INDEX_W-1:0]    block_index;
        logic                  band_done;
        logic [BAND_ROW_W-1:0] band_row;
        logic                  frame_done;
    } addr_info_t;

endpackage

### sv/r2rdb_color.sv
// RGB332 to byte-swapped RGB565 color expansion, white forced for 0xFF.
// Depends on r2rdb_pkg.
`timescale 1ns / 1ps

module r2rdb_color
(
    input  logic [r2rdb_pkg::PIXEL_W-1:0] pixel,
    output logic [r2rdb_pkg::COLOR_W-1:0] color
);
    import r2rdb_pkg::*;

    logic [COLOR_W-1:0] wide;

    // red to 15-13, green to 10-8, blue to 4-3
    assign wide = {pixel[7:5], 2'b00, pixel[4:2], 3'b000, pixel[1:0], 3'b000};

    always_comb
    begin
        if (pixel == PIXEL_WHITE)
        begin
            color = COLOR_WHITE;
        end
        else
        begin
            color = {wide[7:0], wide[15:8]};
        end
    end

endmodule

### sv/r2rdb_addr.sv
// Raster position counters and band buffer addressing for the doubling bander.
// Depends on r2rdb_pkg.
`timescale 1ns / 1ps

module r2rdb_addr
#(
    parameter int SRC_WIDTH  = 160,
    parameter int SRC_HEIGHT = 120,
    parameter int BANDS      = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  logic                  start_of_frame,
    output r2rdb_pkg::addr_info_t info
);
    import r2rdb_pkg::*;

    localparam int RPB_RAW = SRC_HEIGHT / BANDS;
    localparam int RPB     = (RPB_RAW == 0) ? 1 : RPB_RAW;
    localparam int COL_W   = (SRC_WIDTH  > 1) ? $clog2(SRC_WIDTH)  : 1;
    localparam int ROW_W   = (SRC_HEIGHT > 1) ? $clog2(SRC_HEIGHT) : 1;
    localparam int BAND_W  = (BANDS > 1) ? $clog2(BANDS) : 1;

    localparam logic [COL_W-1:0]      LAST_COL   = COL_W'(SRC_WIDTH - 1);
    localparam logic [ROW_W-1:0]      LAST_ROW   = ROW_W'(SRC_HEIGHT - 1);
    localparam logic [ROW_W-1:0]      LAST_LOCAL = ROW_W'(RPB - 1);
    localparam logic [BAND_W-1:0]     LAST_BAND  = BAND_W'(BANDS - 1);
    localparam logic [INDEX_W-1:0]    BASE_STEP  = INDEX_W'((4 * SRC_WIDTH) % (1 << INDEX_W));
    localparam logic [BAND_ROW_W-1:0] BROW_STEP  = BAND_ROW_W'((2 * RPB) % (1 << BAND_ROW_W));

    logic [COL_W-1:0]      col_reg,   col_next,   col_cur;
    logic [ROW_W-1:0]      row_reg,   row_next,   row_cur;
    logic [ROW_W-1:0]      local_reg, local_next, local_cur;
    logic [BAND_W-1:0]     band_reg,  band_next,  band_cur;
    logic [INDEX_W-1:0]    base_reg,  base_next,  base_cur;
    logic [BAND_ROW_W-1:0] brow_reg,  brow_next,  brow_cur;

    logic                  last_col;
    logic                  last_row;
    logic                  local_last;
    logic                  band_last;
    logic [COL_W:0]        col_x2;

    // start of frame restarts the raster before this pixel
    assign col_cur   = start_of_frame ? '0 : col_reg;
    assign row_cur   = start_of_frame ? '0 : row_reg;
    assign local_cur = start_of_frame ? '0 : local_reg;
    assign band_cur  = start_of_frame ? '0 : band_reg;
    assign base_cur  = start_of_frame ? '0 : base_reg;
    assign brow_cur  = start_of_frame ? '0 : brow_reg;

    assign last_col   = (col_cur == LAST_COL);
    assign last_row   = (row_cur == LAST_ROW);
    assign local_last = (local_cur == LAST_LOCAL);
    assign band_last  = (band_cur == LAST_BAND);
    assign col_x2     = {col_cur, 1'b0};

    assign info.block_index = base_cur + INDEX_W'(col_x2);
    assign info.band_row    = brow_cur;
    assign info.frame_done  = last_col && last_row;
    assign info.band_done   = (last_col && last_row) ||
                              (last_col && !band_last && local_last);

    always_comb
    begin
        col_next   = col_cur;
        row_next   = row_cur;
        local_next = local_cur;
        band_next  = band_cur;
        base_next  = base_cur;
        brow_next  = brow_cur;
        if (!last_col)
        begin
            col_next = col_cur + 1'b1;
        end
        else
        begin
            col_next = '0;
            if (last_row)
            begin
                row_next   = '0;
                local_next = '0;
                band_next  = '0;
                base_next  = '0;
                brow_next  = '0;
            end
            else
            begin
                row_next = row_cur + 1'b1;
                if (local_last && !band_last)
                begin
                    local_next = '0;
                    band_next  = band_cur + 1'b1;
                    base_next  = '0;
                    brow_next  = brow_cur + BROW_STEP;
                end
                else
                begin
                    // leftover rows stay in the last band
                    local_next = local_cur + 1'b1;
                    base_next  = base_cur + BASE_STEP;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            local_reg <= '0;
            band_reg  <= '0;
            base_reg  <= '0;
            brow_reg  <= '0;
        end
        else if (advance)
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            local_reg <= local_next;
            band_reg  <= band_next;
            base_reg  <= base_next;
            brow_reg  <= brow_next;
        end
    end

endmodule

### sv/rgb332_to_rgb565_doubling_bander_unit.sv
// RGB332 to RGB565 pixel doubler with band buffer addressing: top level.
// Each source pixel gives its byte-swapped RGB565 color and the top-left index
// of the 2x2 block it fills in a band buffer 2*SRC_WIDTH wide.
// Slave channel: s_tdata = pixel, s_tuser = start_of_frame (clears the raster
// position before that pixel). Master channel: one transaction per pixel with
// block_index, color and band_row in m_tdata, band_done in m_tuser and
// frame_done in m_tlast.
// Pipeline: a pixel accepted into the input register moves to the result register
// once that register is free and is offered on m_tvalid from then on.
// Throughput: one pixel per cycle while m_tready is high; color and address logic is
// a few gates and one 14-bit add between the input register and the result register.
// Reset: both stages empty, column and row counters at the frame origin.
// Stall: with m_tready low the result holds, the input register still fills,
// and s_tready drops only when both stages are full.
// Depends on r2rdb_pkg, r2rdb_color, r2rdb_addr and the assertion macros.
`timescale 1ns / 1ps
`include "rgb332_to_rgb565_doubling_bander_unit_macros.svh"

module rgb332_to_rgb565_doubling_bander_unit
#(
    parameter int SRC_WIDTH  = 160,
    parameter int SRC_HEIGHT = 120,
    parameter int BANDS      = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] pixel
    input  logic        s_tuser,   // [0] start_of_frame
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [13:0] block_index, [29:14] color, [37:30] band_row
    output logic        m_tuser,   // [0] band_done
    output logic        m_tlast    // frame_done
);
    import r2rdb_pkg::*;

    logic                  in_valid_reg;
    logic [PIXEL_W-1:0]    pixel_reg;
    logic                  sof_reg;

    logic                  out_valid_reg;
    logic [INDEX_W-1:0]    index_reg;
    logic [COLOR_W-1:0]    color_reg;
    logic [BAND_ROW_W-1:0] brow_reg;
    logic                  band_done_reg;
    logic                  frame_done_reg;

    logic                  out_free;
    logic                  advance;
    logic [COLOR_W-1:0]    color_w;
    addr_info_t            info_w;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    r2rdb_color u_color
    (
        .pixel (pixel_reg),
        .color (color_w)
    );

    r2rdb_addr
    #(
        .SRC_WIDTH  (SRC_WIDTH),
        .SRC_HEIGHT (SRC_HEIGHT),
        .BANDS      (BANDS)
    )
    u_addr
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .start_of_frame (sof_reg),
        .info           (info_w)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            pixel_reg <= s_tdata;
            sof_reg   <= s_tuser;
        end
        if (advance)
        begin
            index_reg      <= info_w.block_index;
            color_reg      <= color_w;
            brow_reg       <= info_w.band_row;
            band_done_reg  <= info_w.band_done;
            frame_done_reg <= info_w.frame_done;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, brow_reg, color_reg, index_reg};
    assign m_tuser  = band_done_reg;
    assign m_tlast  = frame_done_reg;

    `R2RDB_ASSERT(a_frame_implies_band, m_tvalid && m_tlast |-> m_tuser, "frame_done without band_done")
    `R2RDB_ASSERT(a_stage_moves, in_valid_reg && out_free |=> m_tvalid, "pending pixel not forwarded")
    `R2RDB_ASSERT(a_ready_when_free, !s_tready |-> in_valid_reg && m_tvalid && !m_tready, "input stalled with room")
    `R2RDB_ASSERT_NEVER(a_no_lost_result, m_tvalid && !m_tready && advance, "result overwritten while stalled")

endmodule

### dv/rgb332_to_rgb565_doubling_bander_unit_tb.sv
// Self-checking testbench for rgb332_to_rgb565_doubling_bander_unit: predicts color, block index
// and band flags per pixel and checks every master transaction in order.
// Depends on r2rdb_pkg and the RTL of the unit; reads no files.
`timescale 1ns / 1ps

module rgb332_to_rgb565_doubling_bander_unit_tb;
    import r2rdb_pkg::*;

    localparam int SRC_WIDTH    = 160;
    localparam int SRC_HEIGHT   = 120;
    localparam int BANDS        = 8;
    localparam int RANDOM_ITEMS = 300;
    localparam int WALK_ITEMS   = SRC_WIDTH + 24;
    localparam int QUIET_TAIL   = 100;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 64 * (RANDOM_ITEMS + WALK_ITEMS + 32) + 5000;

    typedef struct {
        logic [INDEX_W-1:0]    block_index;
        logic [COLOR_W-1:0]    color;
        logic                  band_done;
        logic [BAND_ROW_W-1:0] band_row;
        logic                  frame_done;
    } pixel_result_t;

    class raster_predictor;
        pixel_result_t pending_results[$];
        int unsigned   column_pos;
        int unsigned   row_pos;
        int unsigned   rows_per_band;
        int            mismatches;
        int            pixels_in;
        int            results_checked;
        int            bands_closed;
        int            frames_closed;

        function new();
            rows_per_band = SRC_HEIGHT / BANDS;
            if (rows_per_band == 0)
                rows_per_band = 1;
        endfunction

        function logic [COLOR_W-1:0] rgb565_swapped(logic [PIXEL_W-1:0] pix);
            logic [COLOR_W-1:0] c;
            if (pix == PIXEL_WHITE)
                return COLOR_WHITE;
            c = ({8'h00, pix & 8'hE0} << 8) | ({8'h00, pix & 8'h1C} << 6)
                | ({8'h00, pix & 8'h03} << 3);
            return {c[7:0], c[15:8]};
        endfunction

        function void note_pixel(logic [PIXEL_W-1:0] pix, logic sof);
            int unsigned   band;
            int unsigned   band_line;
            int unsigned   idx;
            bit            last_col;
            pixel_result_t e;
            if (sof)
            begin
                column_pos = 0;
                row_pos    = 0;
            end
            band = row_pos / rows_per_band;
            if (band > BANDS - 1)
                band = BANDS - 1;
            band_line = row_pos - band * rows_per_band;
            idx = (2 * band_line) * (2 * SRC_WIDTH) + 2 * column_pos;
            last_col = (column_pos == SRC_WIDTH - 1);
            e.block_index = INDEX_W'(idx);
            e.color       = rgb565_swapped(pix);
            e.frame_done  = last_col && (row_pos == SRC_HEIGHT - 1);
            e.band_done   = e.frame_done
                            || (last_col && band < BANDS - 1 && band_line == rows_per_band - 1);
            e.band_row    = BAND_ROW_W'(band * 2 * rows_per_band);
            pending_results.push_back(e);
            pixels_in++;
            column_pos++;
            if (column_pos >= SRC_WIDTH)
            begin
                column_pos = 0;
                row_pos++;
                if (row_pos >= SRC_HEIGHT)
                    row_pos = 0;
            end
        endfunction

        task report_mismatch(string what, int unsigned got, int unsigned want);
            $display("MISMATCH at result %0d: %s got 0x%0h want 0x%0h",
                     results_checked, what, got, want);
            mismatches++;
        endtask

        task check_block(logic [39:0] data, logic user, logic last);
            pixel_result_t e;
            if (pending_results.size() == 0)
            begin
                report_mismatch("transaction with nothing pending", data[31:0], 0);
                return;
            end
            e = pending_results.pop_front();
            if (data[13:0] !== e.block_index)
                report_mismatch("block_index", data[13:0], e.block_index);
            if (data[29:14] !== e.color)
                report_mismatch("color", data[29:14], e.color);
            if (data[37:30] !== e.band_row)
                report_mismatch("band_row", data[37:30], e.band_row);
            if (user !== e.band_done)
                report_mismatch("band_done", user, e.band_done);
            if (last !== e.frame_done)
                report_mismatch("frame_done", last, e.frame_done);
            if (e.band_done)
                bands_closed++;
            if (e.frame_done)
                frames_closed++;
            results_checked++;
        endtask
    endclass

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    raster_predictor sb;
    bit              quiet     = 1'b0;
    bit              hold_done = 1'b0;
    int              cycle_count;

    rgb332_to_rgb565_doubling_bander_unit #(
        .SRC_WIDTH  (SRC_WIDTH),
        .SRC_HEIGHT (SRC_HEIGHT),
        .BANDS      (BANDS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
        else if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_pixel(s_tdata, s_tuser);
            if (m_tvalid && m_tready)
                sb.check_block(m_tdata, m_tuser, m_tlast);
        end
    end

    // Stall the master side in bursts; hold off once long enough to back up the input.
    initial
    begin : result_sink
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (!hold_done && sb.results_checked >= 30)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    task automatic send_pixel(input logic [7:0] pix, input logic sof);
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tuser  <= sof;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic maybe_pause();
        if (!quiet && $urandom_range(0, 9) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    initial
    begin : pixel_source
        logic [7:0] directed_pixels[16];
        logic       directed_sof[16];
        int         i;
        sb = new();
        directed_pixels = '{8'h00, 8'hFF, 8'hFE, 8'h7F, 8'hE0, 8'h1C, 8'h03, 8'h80,
                            8'h01, 8'h55, 8'hAA, 8'h24, 8'hFF, 8'hDB, 8'h00, 8'hFF};
        directed_sof    = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                            1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_pixels[k])
        begin
            send_pixel(directed_pixels[k], directed_sof[k]);
            maybe_pause();
        end

        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            send_pixel(8'($urandom), $urandom_range(0, 31) == 0);
            maybe_pause();
        end

        // Walk from the frame origin across the first row wrap.
        for (i = 0; i < WALK_ITEMS; i++)
        begin
            if (WALK_ITEMS - i <= QUIET_TAIL)
                quiet = 1'b1;
            send_pixel(8'($urandom), i == 0);
            maybe_pause();
        end
        s_tvalid <= 1'b0;

        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Checked %0d pixel transactions over directed, random and row-wrap traffic",
                 sb.results_checked);
        $display("Band completions seen: %0d, frame completions seen: %0d",
                 sb.bands_closed, sb.frames_closed);
        if (sb.mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### rgb332_to_rgb565_doubling_bander_unit.f
+incdir+sv
sv/r2rdb_pkg.sv
sv/r2rdb_color.sv
sv/r2rdb_addr.sv
sv/rgb332_to_rgb565_doubling_bander_unit.sv
dv/rgb332_to_rgb565_doubling_bander_unit_tb.sv
